>>> rtl/core/mgsp_pkg.sv
// ----------------------------------------------------------------------------
// mgsp_pkg
// Shared widths, codes and defaults of the multistage-graph shortest path block.
// ----------------------------------------------------------------------------
package mgsp_pkg;

    localparam int NODE_W       = 5;
    localparam int NODE_COUNT_W = 6;
    localparam int WEIGHT_W     = 16;
    localparam int COST_W       = 22;
    localparam int EDGE_W       = 2 * NODE_W + WEIGHT_W;

    localparam logic [COST_W-1:0] COST_INF = {COST_W{1'b1}};

    localparam int DEF_MAX_NODES = 32;
    localparam int DEF_MAX_EDGES = 256;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = NODE_COUNT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_NODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_NODE   = 2'd2;

    localparam logic [NODE_COUNT_W-1:0] RST_NODE_COUNT  = 6'd32;
    localparam logic [NODE_W-1:0]       RST_SOURCE_NODE = 5'd0;
    localparam logic [NODE_W-1:0]       RST_DEST_NODE   = 5'd31;

endpackage

>>> rtl/core/mgsp_ram.sv
// ----------------------------------------------------------------------------
// mgsp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mgsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> rtl/core/multistage_graph_shortest_path_top.sv
// ----------------------------------------------------------------------------
// multistage_graph_shortest_path_top
// Backward DP shortest path over a multistage graph loaded edge by edge.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready): one edge per beat. Edges load at
// one per cycle while the block is idle. The beat with i_last_edge set is
// stored if the store has room and starts the solve; o_in_ready stays low
// until the last path beat has been taken.
// Solve: node costs are swept from node n-1 down to 0; for each node the
// whole edge store is scanned through a single add/compare unit: fetch and
// edge states per edge, relax when it leaves the current node with its head
// in range, start and end states per node, and an initial setup state.
// Path walk: each beat goes through node RAM read, format, present, plus
// any stall on the output side; one beat for the source when it is out of
// range. At most MAX_NODES beats; the final one has o_last_in_path set.
// Output channel (o_out_valid / i_out_ready): payload is held in registers
// and stays stable while the receiver stalls; the walk waits for it.
// The user writes configuration (i_cfg_wr_en / i_cfg_index / i_cfg_wdata)
// only when idle; the block itself does not enforce it. Reset empties the
// edge store and restores register defaults.
// ----------------------------------------------------------------------------
module multistage_graph_shortest_path_top
    import mgsp_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int MAX_EDGES = DEF_MAX_EDGES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // edge input
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [NODE_W-1:0]     i_from_node,
    input  logic [NODE_W-1:0]     i_to_node,
    input  logic [WEIGHT_W-1:0]   i_edge_weight,
    input  logic                  i_last_edge,
    // path output
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [NODE_W-1:0]     o_path_node,
    output logic [COST_W-1:0]     o_total_cost,
    output logic                  o_reachable,
    output logic                  o_last_in_path
);

    localparam int NW    = $clog2(MAX_NODES);
    localparam int NCW   = $clog2(MAX_NODES + 1);
    localparam int CMP_W = (NCW > NODE_COUNT_W) ? NCW : NODE_COUNT_W;
    localparam int AW    = $clog2(MAX_EDGES);
    localparam int EW    = $clog2(MAX_EDGES + 1);
    localparam int NR_W  = COST_W + NW;

    typedef enum logic [9:0] {
        S_IDLE       = 10'b00_0000_0001,
        S_INIT       = 10'b00_0000_0010,
        S_NODE_START = 10'b00_0000_0100,
        S_FETCH      = 10'b00_0000_1000,
        S_EDGE       = 10'b00_0001_0000,
        S_RELAX      = 10'b00_0010_0000,
        S_NODE_END   = 10'b00_0100_0000,
        S_WALK_START = 10'b00_1000_0000,
        S_WALK_RD    = 10'b01_0000_0000,
        S_WALK_OUT   = 10'b10_0000_0000
    } t_state;

    // S_EMIT is folded into a flag so the state vector stays at ten codes
    t_state r_state, n_state;
    logic   r_emit;

    // configuration registers
    logic [NODE_COUNT_W-1:0] r_node_count;
    logic [NODE_W-1:0]       r_source_node;
    logic [NODE_W-1:0]       r_dest_node;

    // datapath registers
    logic [EW-1:0]        r_edges;
    logic [EW-1:0]        r_k;
    logic [NCW-1:0]       r_n;
    logic [NW-1:0]        r_v;
    logic [COST_W-1:0]    r_cur_cost;
    logic [NW-1:0]        r_cur_succ;
    logic                 r_cur_has;
    logic [NW-1:0]        r_eh;
    logic [WEIGHT_W-1:0]  r_ew;
    logic [MAX_NODES-1:0] r_valid;
    logic [NW-1:0]        r_wv;
    logic [NW-1:0]        r_next;
    logic [NW-1:0]        r_cnt;
    logic [COST_W-1:0]    r_total;
    logic                 r_more;

    logic                 in_acc, out_acc, edge_we;
    logic [EDGE_W-1:0]    edge_rdata;
    logic [NR_W-1:0]      node_rdata;
    logic [NW-1:0]        node_raddr;
    logic                 node_we;

    logic [NODE_W-1:0]    e_tail, e_head;
    logic [WEIGHT_W-1:0]  e_weight;
    logic [CMP_W-1:0]     nc_ext, n_ext, v_ext, tail_ext, head_ext, dest_ext, src_ext;
    logic [NCW-1:0]       n_eff;
    logic [COST_W-1:0]    rd_cost, h_cost, cand, walk_cost, walk_total;
    logic [NW-1:0]        rd_succ;
    logic [COST_W:0]      sum;
    logic                 walk_more;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && !r_emit;
    assign o_out_valid = r_emit;

    assign edge_we = in_acc && (r_edges < EW'(MAX_EDGES));

    mgsp_ram #(
        .WIDTH (EDGE_W),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (r_edges[AW-1:0]),
        .i_wdata ({i_from_node, i_to_node, i_edge_weight}),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (edge_rdata)
    );

    assign e_tail   = edge_rdata[EDGE_W-1 -: NODE_W];
    assign e_head   = edge_rdata[WEIGHT_W +: NODE_W];
    assign e_weight = edge_rdata[WEIGHT_W-1:0];

    assign nc_ext   = CMP_W'(r_node_count);
    assign n_ext    = CMP_W'(r_n);
    assign v_ext    = CMP_W'(r_v);
    assign tail_ext = CMP_W'(e_tail);
    assign head_ext = CMP_W'(e_head);
    assign dest_ext = CMP_W'(r_dest_node);
    assign src_ext  = CMP_W'(r_source_node);

    always_comb begin
        if (nc_ext == '0) begin
            n_eff = NCW'(1);
        end else if (nc_ext > CMP_W'(MAX_NODES)) begin
            n_eff = NCW'(MAX_NODES);
        end else begin
            n_eff = nc_ext[NCW-1:0];
        end
    end

    // node RAM holds {best cost, successor}; only valid entries are used
    assign node_raddr = (r_state == S_WALK_RD) ? r_wv : head_ext[NW-1:0];
    assign node_we    = (r_state == S_NODE_END) && r_cur_has;

    mgsp_ram #(
        .WIDTH (NR_W),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (r_v),
        .i_wdata ({r_cur_cost, r_cur_succ}),
        .i_raddr (node_raddr),
        .o_rdata (node_rdata)
    );

    assign rd_cost = node_rdata[NR_W-1 -: COST_W];
    assign rd_succ = node_rdata[NW-1:0];

    // shared add / saturate / compare unit
    always_comb begin
        if (CMP_W'(r_eh) == dest_ext) begin
            h_cost = '0;
        end else if (r_valid[r_eh]) begin
            h_cost = rd_cost;
        end else begin
            h_cost = COST_INF;
        end
        sum  = (COST_W+1)'(r_ew) + {1'b0, h_cost};
        cand = (sum >= {1'b0, COST_INF}) ? COST_INF : sum[COST_W-1:0];
    end

    always_comb begin
        if (CMP_W'(r_wv) == dest_ext) begin
            walk_cost = '0;
        end else if (r_valid[r_wv]) begin
            walk_cost = rd_cost;
        end else begin
            walk_cost = COST_INF;
        end
        walk_total = (r_cnt == '0) ? walk_cost : r_total;
        walk_more  = r_valid[r_wv] && ((NCW'(r_cnt) + NCW'(1)) < NCW'(MAX_NODES));
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_last_edge) begin
                    n_state = S_INIT;
                end
            end
            S_INIT:       n_state = S_NODE_START;
            S_NODE_START: n_state = S_FETCH;
            S_FETCH:      n_state = (r_k == r_edges) ? S_NODE_END : S_EDGE;
            S_EDGE: begin
                if (tail_ext == v_ext && head_ext < n_ext) begin
                    n_state = S_RELAX;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_RELAX:      n_state = S_FETCH;
            S_NODE_END:   n_state = (r_v == '0) ? S_WALK_START : S_NODE_START;
            S_WALK_START: n_state = (src_ext >= n_ext) ? S_IDLE : S_WALK_RD;
            S_WALK_RD:    n_state = S_WALK_OUT;
            S_WALK_OUT:   n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
        // presenting a beat: park in S_IDLE with r_emit, resume walk on accept
        if (r_emit) begin
            n_state = out_acc ? (r_more ? S_WALK_RD : S_IDLE) : r_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_emit        <= 1'b0;
            r_node_count  <= RST_NODE_COUNT;
            r_source_node <= RST_SOURCE_NODE;
            r_dest_node   <= RST_DEST_NODE;
            r_edges       <= '0;
            r_valid       <= '0;
            r_more        <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_NODE_COUNT:  r_node_count  <= i_cfg_wdata;
                    CFG_SOURCE_NODE: r_source_node <= i_cfg_wdata[NODE_W-1:0];
                    CFG_DEST_NODE:   r_dest_node   <= i_cfg_wdata[NODE_W-1:0];
                    default: ;
                endcase
            end

            if (edge_we) begin
                r_edges <= r_edges + EW'(1);
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_last_edge) begin
                        r_n <= n_eff;
                    end
                end
                S_INIT: begin
                    r_valid <= '0;
                    r_v     <= NW'(r_n - NCW'(1));
                end
                S_NODE_START: begin
                    r_k        <= '0;
                    r_cur_cost <= (v_ext == dest_ext) ? '0 : COST_INF;
                    r_cur_has  <= 1'b0;
                end
                S_EDGE: begin
                    r_eh <= head_ext[NW-1:0];
                    r_ew <= e_weight;
                    if (!(tail_ext == v_ext && head_ext < n_ext)) begin
                        r_k <= r_k + EW'(1);
                    end
                end
                S_RELAX: begin
                    r_k <= r_k + EW'(1);
                    if (r_cur_cost > cand) begin
                        r_cur_cost <= cand;
                        r_cur_succ <= r_eh;
                        r_cur_has  <= 1'b1;
                    end
                end
                S_NODE_END: begin
                    r_valid[r_v] <= r_cur_has;
                    if (r_v == '0) begin
                        r_edges <= '0;
                    end else begin
                        r_v <= r_v - NW'(1);
                    end
                end
                S_WALK_START: begin
                    r_cnt <= '0;
                    r_wv  <= src_ext[NW-1:0];
                    if (src_ext >= n_ext) begin
                        o_path_node    <= r_source_node;
                        o_total_cost   <= COST_INF;
                        o_reachable    <= 1'b0;
                        o_last_in_path <= 1'b1;
                        r_more         <= 1'b0;
                        r_emit         <= 1'b1;
                    end
                end
                S_WALK_OUT: begin
                    r_total        <= walk_total;
                    r_next         <= rd_succ;
                    r_more         <= walk_more;
                    o_path_node    <= NODE_W'(CMP_W'(r_wv));
                    o_total_cost   <= walk_total;
                    o_reachable    <= (walk_total != COST_INF);
                    o_last_in_path <= !walk_more;
                    r_emit         <= 1'b1;
                end
                default: ;
            endcase

            if (out_acc) begin
                r_emit <= 1'b0;
                if (r_more) begin
                    r_wv  <= r_next;
                    r_cnt <= r_cnt + NW'(1);
                end
            end
        end
    end

endmodule

>>> test/mgsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgsp_checker
// Watches the edge, path and register ports of the shortest path block, keeps
// its own copy of the edge store and node costs, solves each graph when the
// last edge goes in, and compares every path beat with the oldest prediction.
// ----------------------------------------------------------------------------
module mgsp_checker
    import mgsp_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int MAX_EDGES = DEF_MAX_EDGES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [NODE_W-1:0]     i_from_node,
    input  logic [NODE_W-1:0]     i_to_node,
    input  logic [WEIGHT_W-1:0]   i_edge_weight,
    input  logic                  i_last_edge,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [NODE_W-1:0]     i_path_node,
    input  logic [COST_W-1:0]     i_total_cost,
    input  logic                  i_reachable,
    input  logic                  i_last_in_path,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_edges_seen,
    output int                    o_solves,
    output int                    o_unreachable,
    output int                    o_beats_checked
);

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [COST_W-1:0] cost;
        logic              reachable;
        logic              last;
    } t_path_beat;

    t_path_beat expected_path_q[$];

    logic [NODE_COUNT_W-1:0] node_count_reg;
    logic [NODE_W-1:0]       source_reg;
    logic [NODE_W-1:0]       dest_reg;

    logic [NODE_W-1:0]   tail_mem[MAX_EDGES];
    logic [NODE_W-1:0]   head_mem[MAX_EDGES];
    logic [WEIGHT_W-1:0] weight_mem[MAX_EDGES];
    int unsigned         edges_held;

    logic [COST_W-1:0] best_cost[MAX_NODES];
    int unsigned       succ[MAX_NODES];
    bit                has_succ[MAX_NODES];

    int fail_count    = 0;
    int edges_seen    = 0;
    int solves        = 0;
    int unreachable   = 0;
    int beats_checked = 0;

    // backward sweep over the held edges, then the walk along successor links
    task automatic solve_graph();
        int unsigned n, idx, v, k, h, cur, count;
        logic [31:0] sum;
        logic [COST_W-1:0] total;
        bit more, going;
        t_path_beat beat;
        n = node_count_reg;
        if (n == 0)
            n = 1;
        if (n > MAX_NODES)
            n = MAX_NODES;
        for (v = 0; v < n; v++) begin
            best_cost[v] = COST_INF;
            has_succ[v]  = 1'b0;
            succ[v]      = 0;
        end
        if (dest_reg < n)
            best_cost[dest_reg] = '0;
        for (idx = n; idx > 0; idx--) begin
            v = idx - 1;
            for (k = 0; k < edges_held; k++) begin
                h = head_mem[k];
                if (tail_mem[k] == v && h < n) begin
                    sum = weight_mem[k] + best_cost[h];
                    if (sum >= COST_INF)
                        sum = COST_INF;
                    if (best_cost[v] > sum) begin
                        best_cost[v] = sum[COST_W-1:0];
                        succ[v]      = h;
                        has_succ[v]  = 1'b1;
                    end
                end
            end
        end
        solves++;
        if (source_reg >= n) begin
            beat = '{source_reg, COST_INF, 1'b0, 1'b1};
            expected_path_q = {expected_path_q, beat};
            unreachable++;
            return;
        end
        total = best_cost[source_reg];
        if (total == COST_INF)
            unreachable++;
        cur   = source_reg;
        count = 0;
        going = 1'b1;
        while (going) begin
            more = has_succ[cur] && (count + 1 < MAX_NODES);
            beat.node      = cur[NODE_W-1:0];
            beat.cost      = total;
            beat.reachable = (total != COST_INF);
            beat.last      = !more;
            expected_path_q = {expected_path_q, beat};
            count++;
            if (more)
                cur = succ[cur];
            else
                going = 1'b0;
        end
    endtask

    task automatic compare_field(input string name, input logic [COST_W-1:0] exp_val,
                                 input logic [COST_W-1:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t path beat %s mismatch: expected %0h, got %0h",
                     $time, name, exp_val, act_val);
            fail_count++;
        end
    endtask

    task automatic check_path_beat();
        t_path_beat exp_beat;
        if (expected_path_q.size() == 0) begin
            $display("%0t unexpected path beat: expected none, got node %0d cost %0h",
                     $time, i_path_node, i_total_cost);
            fail_count++;
            return;
        end
        exp_beat = expected_path_q.pop_front();
        beats_checked++;
        compare_field("path_node", exp_beat.node, i_path_node);
        compare_field("total_cost", exp_beat.cost, i_total_cost);
        compare_field("reachable", exp_beat.reachable, i_reachable);
        compare_field("last_in_path", exp_beat.last, i_last_in_path);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            node_count_reg = RST_NODE_COUNT;
            source_reg     = RST_SOURCE_NODE;
            dest_reg       = RST_DEST_NODE;
            edges_held     = 0;
            expected_path_q.delete();
        end else begin
            // drain side first so a beat never meets a prediction made this edge
            if (i_out_valid === 1'b1 && i_out_ready)
                check_path_beat();
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_NODE_COUNT:  node_count_reg = i_cfg_wdata;
                    CFG_SOURCE_NODE: source_reg = i_cfg_wdata[NODE_W-1:0];
                    CFG_DEST_NODE:   dest_reg = i_cfg_wdata[NODE_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready === 1'b1) begin
                edges_seen++;
                // a full store drops the edge, but a last edge still starts the solve
                if (edges_held < MAX_EDGES) begin
                    tail_mem[edges_held]   = i_from_node;
                    head_mem[edges_held]   = i_to_node;
                    weight_mem[edges_held] = i_edge_weight;
                    edges_held++;
                end
                if (i_last_edge) begin
                    solve_graph();
                    edges_held = 0;
                end
            end
        end
        o_fail_count    <= fail_count;
        o_pending       <= expected_path_q.size();
        o_edges_seen    <= edges_seen;
        o_solves        <= solves;
        o_unreachable   <= unreachable;
        o_beats_checked <= beats_checked;
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives edge graphs and register settings into the shortest path block with
// random gaps and output stalls; the checker predicts and compares the paths.
// ----------------------------------------------------------------------------
module tb_top;
    import mgsp_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 9;
    localparam int GAP_PCT        = 35;
    localparam int HOLD_CYCLES    = 500;
    localparam int SETTLE_CYCLES  = 16;
    localparam int RANDOM_ITEMS   = 360;
    localparam int WATCHDOG_LIMIT = 200000;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = CFG_NODE_COUNT;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  in_valid      = 1'b0;
    logic [NODE_W-1:0]     from_node     = '0;
    logic [NODE_W-1:0]     to_node       = '0;
    logic [WEIGHT_W-1:0]   edge_weight   = '0;
    logic                  last_edge     = 1'b0;
    logic                  out_ready     = 1'b0;

    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [NODE_W-1:0]     o_path_node;
    logic [COST_W-1:0]     o_total_cost;
    logic                  o_reachable;
    logic                  o_last_in_path;

    int fail_count, pending, edges_seen, solves, unreachable, beats_checked;

    bit tx_gaps     = 1'b1;
    bit rx_gaps     = 1'b1;
    int hold_asked  = 0;
    int hold_served = 0;
    int stall_cycles = 0;

    multistage_graph_shortest_path_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_from_node    (from_node),
        .i_to_node      (to_node),
        .i_edge_weight  (edge_weight),
        .i_last_edge    (last_edge),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_path_node    (o_path_node),
        .o_total_cost   (o_total_cost),
        .o_reachable    (o_reachable),
        .o_last_in_path (o_last_in_path)
    );

    mgsp_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .i_in_ready      (o_in_ready),
        .i_from_node     (from_node),
        .i_to_node       (to_node),
        .i_edge_weight   (edge_weight),
        .i_last_edge     (last_edge),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .i_path_node     (o_path_node),
        .i_total_cost    (o_total_cost),
        .i_reachable     (o_reachable),
        .i_last_in_path  (o_last_in_path),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_edges_seen    (edges_seen),
        .o_solves        (solves),
        .o_unreachable   (unreachable),
        .o_beats_checked (beats_checked)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // called at a rising edge; returns at the edge that takes the beat
    task automatic send_edge(input logic [NODE_W-1:0] f, input logic [NODE_W-1:0] t,
                             input logic [WEIGHT_W-1:0] w, input logic l);
        while (tx_gaps && $urandom_range(99) < GAP_PCT) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid    <= 1'b1;
        from_node   <= f;
        to_node     <= t;
        edge_weight <= w;
        last_edge   <= l;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_config(input logic [NODE_COUNT_W-1:0] count,
                                input logic [NODE_W-1:0] src, input logic [NODE_W-1:0] dst);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_NODE_COUNT;
        cfg_wdata <= count;
        @(posedge i_clk);
        cfg_index <= CFG_SOURCE_NODE;
        cfg_wdata <= {1'b0, src};
        @(posedge i_clk);
        cfg_index <= CFG_DEST_NODE;
        cfg_wdata <= {1'b0, dst};
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin : receiver
        int held;
        forever begin
            @(posedge i_clk);
            if (hold_asked != hold_served) begin
                hold_served++;
                out_ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge i_clk);
            end
            out_ready <= !rx_gaps || ($urandom_range(99) >= GAP_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready === 1'b1) ||
            (o_out_valid === 1'b1 && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no beat in %0d cycles", $time, WATCHDOG_LIMIT);
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        int phase, items, graphs, g, e, ne, sel, n_eff, src, dst, f, t, w;
        logic [NODE_COUNT_W-1:0] raw_count;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register defaults: 32 nodes, path from 0 to 31; equal cost keeps the earlier edge
        send_edge(0, 31, 16'hFFFF, 1'b0);
        send_edge(0, 5, 16'h0000, 1'b0);
        send_edge(5, 31, 16'hFFFF, 1'b1);

        // ties, an edge with head past the count and one with tail past it
        write_config(6'd4, 5'd0, 5'd3);
        send_edge(0, 1, 1, 1'b0);
        send_edge(1, 3, 2, 1'b0);
        send_edge(0, 2, 0, 1'b0);
        send_edge(2, 3, 3, 1'b0);
        send_edge(3, 7, 0, 1'b0);
        send_edge(9, 3, 0, 1'b0);
        send_edge(1, 2, 0, 1'b1);

        // zero node count acts as one node
        write_config(6'd0, 5'd0, 5'd0);
        send_edge(0, 0, 5, 1'b1);

        // count above the node limit clamps to 32
        write_config(6'd63, 5'd31, 5'd0);
        send_edge(31, 0, 16'h8000, 1'b1);

        // source beyond the node count
        write_config(6'd3, 5'd5, 5'd0);
        send_edge(1, 0, 7, 1'b1);

        // destination beyond the node count: nothing reachable
        write_config(6'd5, 5'd1, 5'd7);
        send_edge(1, 2, 3, 1'b0);
        send_edge(2, 3, 4, 1'b1);

        // source with no route to the destination
        write_config(6'd5, 5'd0, 5'd4);
        send_edge(1, 4, 2, 1'b0);
        send_edge(2, 0, 1, 1'b1);

        phase = 0;
        items = 0;
        while (items < RANDOM_ITEMS) begin
            case (phase)
                2: begin
                    raw_count = 6'd32;
                    src = 0;
                    dst = 31;
                end
                5: begin
                    raw_count = 6'd32;
                    src = $urandom_range(15, 0);
                    dst = $urandom_range(31, 16);
                end
                default: begin
                    sel = $urandom_range(99);
                    if (sel < 15)
                        raw_count = NODE_COUNT_W'($urandom_range(63, 32));
                    else if (sel < 25)
                        raw_count = NODE_COUNT_W'($urandom_range(1, 0));
                    else if (sel < 40)
                        raw_count = NODE_COUNT_W'($urandom_range(31, 13));
                    else
                        raw_count = NODE_COUNT_W'($urandom_range(12, 2));
                    n_eff = (raw_count == 0) ? 1 : ((raw_count > 32) ? 32 : raw_count);
                    src = ($urandom_range(99) < 85) ? $urandom_range((n_eff - 1) / 2, 0)
                                                    : $urandom_range(31, 0);
                    sel = $urandom_range(99);
                    if (sel < 50)
                        dst = n_eff - 1;
                    else if (sel < 85)
                        dst = $urandom_range(n_eff - 1, 0);
                    else
                        dst = $urandom_range(31, 0);
                end
            endcase
            n_eff = (raw_count == 0) ? 1 : ((raw_count > 32) ? 32 : raw_count);
            write_config(raw_count, NODE_W'(src), NODE_W'(dst));
            tx_gaps = (phase != 1);
            rx_gaps = (phase != 1);
            graphs = (phase == 3) ? 3 : $urandom_range(4, 1);
            for (g = 0; g < graphs; g++) begin
                // receiver holds off while the next graph is already offered
                if (phase == 3 && g == 0)
                    hold_asked++;
                if (phase == 2 && g == 0) begin
                    // costly direct edge first, then a cheap chain through every node
                    send_edge(0, 31, 16'hFFFF, 1'b0);
                    for (e = 30; e >= 0; e--)
                        send_edge(NODE_W'(e), NODE_W'(e + 1),
                                  WEIGHT_W'($urandom_range(2047, 0)), e == 0);
                    ne = 32;
                end else begin
                    // first graph of phase 5 overflows the edge store
                    ne = (phase == 5 && g == 0) ? DEF_MAX_EDGES + 4 : $urandom_range(12, 2);
                    for (e = 0; e < ne; e++) begin
                        sel = $urandom_range(99);
                        if (sel < 70 && n_eff > 1) begin
                            f = $urandom_range(n_eff - 2, 0);
                            t = $urandom_range(n_eff - 1, f + 1);
                        end else if (sel < 82) begin
                            f = $urandom_range(31, 0);
                            t = $urandom_range(31, 0);
                        end else if (sel < 92) begin
                            f = $urandom_range(n_eff - 1, 0);
                            t = dst;
                        end else begin
                            f = $urandom_range(n_eff - 1, 0);
                            t = $urandom_range(n_eff - 1, 0);
                        end
                        sel = $urandom_range(99);
                        if (sel < 8)
                            w = 0;
                        else if (sel < 16)
                            w = 16'hFFFF;
                        else if (sel < 50)
                            w = $urandom_range(15, 0);  // small weights make ties
                        else
                            w = $urandom_range(16'hFFFF, 0);
                        send_edge(NODE_W'(f), NODE_W'(t), WEIGHT_W'(w), e == ne - 1);
                    end
                end
                items += ne;
                if (phase != 3 && $urandom_range(3) == 0)
                    wait_drained();
            end
            phase++;
        end

        wait_drained();
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);
        $display("run: %0d edge beats over %0d random register settings plus directed cases",
                 edges_seen, phase);
        $display("run: %0d graphs solved, %0d without a route, %0d path beats compared",
                 solves, unreachable, beats_checked);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> multistage_graph_shortest_path_top.f
rtl/core/mgsp_pkg.sv
rtl/core/mgsp_ram.sv
rtl/core/multistage_graph_shortest_path_top.sv
test/mgsp_checker.sv
test/tb_top.sv
